[hw/rtl/abb_pkg.sv]
// ----------------------------------------------------------------------------
// abb_pkg: shared types and constants of the adaptive binarizer
// Configuration layout, queue entry and fixed arithmetic constants.
// ----------------------------------------------------------------------------
package abb_pkg;

  localparam int unsigned PIXEL_W  = 8;
  localparam int unsigned MEAN_W   = 16;
  localparam int unsigned SHIFT_W  = 3;
  localparam int unsigned PCT_W    = 7;

  // Register indexes on the configuration channel
  typedef enum logic [1:0] {
    REG_ENABLE            = 2'd0,
    REG_AVG_SHIFT         = 2'd1,
    REG_THRESHOLD_PERCENT = 2'd2,
    REG_INITIAL_LEVEL     = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic                 enable;
    logic [SHIFT_W-1:0]   avg_shift;
    logic [PCT_W-1:0]     threshold_percent;
    logic [PIXEL_W-1:0]   initial_level;
  } cfg_t;

  localparam logic               ENABLE_RESET  = 1'b1;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET   = 3'd5;
  localparam logic [PCT_W-1:0]   PCT_RESET     = 7'd15;
  localparam logic [PIXEL_W-1:0] LEVEL_RESET   = 8'd30;
  localparam logic [MEAN_W-1:0]  MEAN_RESET    = 16'(LEVEL_RESET) << SHIFT_RESET;

  // Tone curve: square and scale below the knee, saturate to white from the knee up
  localparam logic [PIXEL_W-1:0] KNEE          = 8'd150;
  localparam logic [PIXEL_W-1:0] WHITE         = 8'hFF;
  // floor(x / 150) == (x * RECIP_KNEE) >> RECIP_SHIFT for x < 28728
  localparam logic [14:0]        RECIP_KNEE    = 15'd27963;
  localparam int unsigned        RECIP_SHIFT   = 22;

  localparam logic [PCT_W-1:0]   PCT_FULL      = 7'd100;
  localparam logic [MEAN_W-1:0]  MEAN_MAX      = 16'hFFFF;

  // One entry of the front-to-back queue
  typedef struct packed {
    logic               fs;      // reload mean and clear packer first
    logic               pix;     // pixel takes part in binarization
    logic [PIXEL_W-1:0] pixel;   // tone-mapped pixel
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[hw/rtl/abb_if.sv]
// ----------------------------------------------------------------------------
// abb_if: handshake channels of the adaptive binarizer
// Pixel input, packed byte output and configuration write channels.
// ----------------------------------------------------------------------------
interface abb_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface abb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;

  modport source (output valid, output packed_byte, input ready);
  modport sink   (input valid, input packed_byte, output ready);
endinterface

interface abb_cfg_if;
  logic                valid;
  logic                ready;
  abb_pkg::cfg_index_t index;
  logic [7:0]          data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/abb_front.sv]
// ----------------------------------------------------------------------------
// abb_front: pixel intake and tone mapping
// Accepts pixels, drops those with no effect, maps the rest and queues them.
// ----------------------------------------------------------------------------
module abb_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              enable,
  abb_pix_if.sink           pixels,
  input  abb_pkg::q_status_t q_status,
  output logic              push,
  output abb_pkg::q_item_t  push_item
);
  import abb_pkg::*;

  // Stage 1: square
  logic         s1_valid;
  logic         s1_fs;
  logic         s1_pix;
  logic         s1_knee;
  logic [15:0]  s1_sq;
  // Stage 2: scale by 1/150
  logic         s2_valid;
  q_item_t      s2_item;

  logic         s1_adv;
  logic         accept;
  logic         keep;
  logic [29:0]  scaled;

  assign push          = s2_valid && !q_status.full;
  assign s1_adv        = !s2_valid || push;
  assign pixels.ready  = !s1_valid || s1_adv;
  assign accept        = pixels.valid && pixels.ready;
  // a disabled pixel without frame start changes nothing: drop it here
  assign keep          = enable || pixels.frame_start;
  assign scaled        = 30'(s1_sq[14:0]) * 30'(RECIP_KNEE);
  assign push_item     = s2_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (pixels.ready) begin
        s1_valid <= accept && keep;
      end
      if (s1_adv) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pixels.ready) begin
      s1_fs   <= pixels.frame_start;
      s1_pix  <= enable;
      s1_knee <= pixels.pixel >= KNEE;
      s1_sq   <= 16'(pixels.pixel) * 16'(pixels.pixel);
    end
    if (s1_adv) begin
      s2_item.fs    <= s1_fs;
      s2_item.pix   <= s1_pix;
      s2_item.pixel <= s1_knee ? WHITE : scaled[RECIP_SHIFT +: PIXEL_W];
    end
  end

endmodule

[hw/rtl/abb_queue.sv]
// ----------------------------------------------------------------------------
// abb_queue: short FIFO between front and back
// Holds mapped pixels so the front keeps accepting while the back stalls.
// ----------------------------------------------------------------------------
module abb_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  abb_pkg::q_item_t   push_item,
  input  logic               pop,
  output abb_pkg::q_item_t   head,
  output abb_pkg::q_status_t status
);
  import abb_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  q_item_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head         = mem[rd_ptr];
  assign status.full  = count == CNT_FULL;
  assign status.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/abb_back.sv]
// ----------------------------------------------------------------------------
// abb_back: running mean, threshold compare and bit packer
// Pops queued pixels, updates the mean, decides each bit and packs bytes.
// ----------------------------------------------------------------------------
module abb_back (
  input  logic               clk,
  input  logic               rst,
  input  abb_pkg::cfg_t      cfg_regs,
  input  abb_pkg::q_item_t   head,
  input  abb_pkg::q_status_t q_status,
  output logic               pop,
  abb_byte_if.source         bytes
);
  import abb_pkg::*;

  logic [MEAN_W-1:0]  mean_sum;
  logic [MEAN_W-1:0]  mean_sum_next;
  logic [MEAN_W-1:0]  reload;
  logic [MEAN_W-1:0]  base;
  logic [MEAN_W:0]    sum_wide;
  logic [MEAN_W-1:0]  updated;

  // Stage A: mean updated
  logic               a_valid;
  logic               a_fs;
  logic               a_pix;
  logic [PIXEL_W-1:0] a_pixel;
  logic [MEAN_W-1:0]  a_avg;

  // Stage B: bit decided
  logic               b_valid;
  logic               b_fs;
  logic               b_pix;
  logic               b_bit;

  logic [PCT_W-1:0]   pct_keep;
  logic [22:0]        thr_scaled;
  logic [14:0]        pix_scaled;

  logic [PIXEL_W-1:0] bit_buffer;
  logic [PIXEL_W-1:0] bit_buffer_next;
  logic [2:0]         bit_position;
  logic [2:0]         bit_position_next;
  logic [PIXEL_W-1:0] byte_val;
  logic               emit;

  logic               out_valid;
  logic [PIXEL_W-1:0] out_byte;
  logic               adv;

  // whole back end holds while a finished byte waits
  assign adv               = !out_valid || bytes.ready;
  assign pop               = adv && !q_status.empty;
  assign bytes.valid       = out_valid;
  assign bytes.packed_byte = out_byte;

  always_comb begin
    reload   = 16'(cfg_regs.initial_level) << cfg_regs.avg_shift;
    base     = head.fs ? reload : mean_sum;
    sum_wide = 17'(base) - 17'(base >> cfg_regs.avg_shift) + 17'(head.pixel);
    updated  = sum_wide[MEAN_W] ? MEAN_MAX : sum_wide[MEAN_W-1:0];
    mean_sum_next = mean_sum;
    if (pop) begin
      if (head.pix) begin
        mean_sum_next = updated;
      end else if (head.fs) begin
        mean_sum_next = reload;
      end
    end
  end

  // pixel > floor(Y / 100)  <=>  100 * pixel > Y
  always_comb begin
    pct_keep   = (cfg_regs.threshold_percent > PCT_FULL) ? '0
                                                         : PCT_FULL - cfg_regs.threshold_percent;
    thr_scaled = 23'(a_avg) * 23'(pct_keep);
    pix_scaled = 15'(a_pixel) * 15'(PCT_FULL);
  end

  always_comb begin
    bit_buffer_next   = bit_buffer;
    bit_position_next = bit_position;
    byte_val          = bit_buffer;
    emit              = 1'b0;
    if (b_valid) begin
      if (b_fs) begin
        bit_buffer_next   = '0;
        bit_position_next = '0;
      end
      if (b_pix) begin
        if (b_bit) begin
          bit_buffer_next[~bit_position_next] = 1'b1;
        end
        byte_val = bit_buffer_next;
        if (bit_position_next == 3'd7) begin
          emit              = 1'b1;
          bit_buffer_next   = '0;
          bit_position_next = '0;
        end else begin
          bit_position_next = bit_position_next + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_sum     <= MEAN_RESET;
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      bit_buffer   <= '0;
      bit_position <= '0;
      out_valid    <= 1'b0;
    end else if (adv) begin
      mean_sum     <= mean_sum_next;
      a_valid      <= pop;
      b_valid      <= a_valid;
      bit_buffer   <= bit_buffer_next;
      bit_position <= bit_position_next;
      out_valid    <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_fs    <= head.fs;
      a_pix   <= head.pix;
      a_pixel <= head.pixel;
      a_avg   <= updated >> cfg_regs.avg_shift;
      b_fs    <= a_fs;
      b_pix   <= a_pix;
      b_bit   <= 23'(pix_scaled) > thr_scaled;
      if (emit) begin
        out_byte <= byte_val;
      end
    end
  end

endmodule

[hw/rtl/adaptive_binarize_bitpack.sv]
// ----------------------------------------------------------------------------
// adaptive_binarize_bitpack: running-mean binarizer with MSB-first bit packer
// Top level: configuration registers, front, queue and back end.
// ----------------------------------------------------------------------------
// Usage:
//   pixels : one luminance byte per transfer, frame_start on a frame's first
//            pixel (reloads the mean from initial_level and drops any partial
//            byte, even while disabled).
//   bytes  : one packed byte per eight enabled pixels, first pixel in bit 7.
//   cfg    : register writes (enable, avg_shift, threshold_percent,
//            initial_level); always ready. Write only while the block is idle.
// Throughput: one pixel per cycle sustained while bytes.ready keeps up; the mean
//   update is a single add-and-saturate that feeds back into the mean register.
// Path: the eighth pixel of a byte passes the two tone-mapping stages, the queue,
//   the mean stage and the compare stage; the byte is then registered as valid.
// Stall: while a byte waits on bytes.ready the back end holds; the front keeps
//   taking pixels until the queue (QUEUE_DEPTH entries) and its two stages fill.
// Reset: registers go to their defaults, mean to 960, packer empty, no byte
//   pending; the block takes pixels in the cycle after reset.
// ----------------------------------------------------------------------------
module adaptive_binarize_bitpack #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  abb_pix_if.sink    pixels,
  abb_byte_if.source bytes,
  abb_cfg_if.sink    cfg
);
  import abb_pkg::*;

  cfg_t      cfg_regs;
  q_item_t   push_item;
  q_item_t   head;
  q_status_t q_status;
  logic      push;
  logic      pop;

  // Configuration writes are never held off
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.enable            <= ENABLE_RESET;
      cfg_regs.avg_shift         <= SHIFT_RESET;
      cfg_regs.threshold_percent <= PCT_RESET;
      cfg_regs.initial_level     <= LEVEL_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ENABLE:            cfg_regs.enable            <= cfg.data[0];
        REG_AVG_SHIFT:         cfg_regs.avg_shift         <= cfg.data[SHIFT_W-1:0];
        REG_THRESHOLD_PERCENT: cfg_regs.threshold_percent <= cfg.data[PCT_W-1:0];
        REG_INITIAL_LEVEL:     cfg_regs.initial_level     <= cfg.data;
        default: ;
      endcase
    end
  end

  // Front: take pixels, drop disabled ones without frame start, tone-map the rest
  abb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .enable    (cfg_regs.enable),
    .pixels    (pixels),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  // Decouple front from back
  abb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // Back: mean, threshold and packing; advance only when output can move
  abb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .bytes    (bytes)
  );

  // No push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("queue push while full");

  // No pop from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("queue pop while empty");

  // A pushed item is in the queue the cycle after
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> !q_status.empty)
    else $error("pushed item not held in queue");

endmodule

[tb/adaptive_binarize_bitpack_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adaptive_binarize_bitpack_tb: self-checking bench of the adaptive binarizer
// Streams luminance pixels through the block under several register settings.
// A scoreboard predicts every packed byte from its own copy of the running
// mean and the bit packer, and compares each output transfer against it.
// ----------------------------------------------------------------------------
module adaptive_binarize_bitpack_tb;
  import abb_pkg::*;

  localparam int unsigned PHASE_COUNT  = 14;
  localparam int unsigned PHASE_PIXELS = 118;  // pixels per enabled phase
  localparam int unsigned OFF_PIXELS   = 24;   // pixels per disabled phase
  localparam int unsigned SETTLE       = 12;   // idle wait that lets the pipeline drain
  localparam int unsigned HOLD_CYCLES  = 250;  // long output back-pressure
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // Predicts packed bytes from accepted pixels and keeps them in order.
  class pack_scoreboard;
    logic                 en;
    logic [SHIFT_W-1:0]   shift;
    logic [PCT_W-1:0]     pct;
    logic [PIXEL_W-1:0]   level;
    logic [MEAN_W-1:0]    mean;
    logic [7:0]           bit_acc;
    logic [2:0]           bit_cnt;
    logic [7:0]           pending_bytes[$];
    int unsigned          errors;

    function new();
      en      = ENABLE_RESET;
      shift   = SHIFT_RESET;
      pct     = PCT_RESET;
      level   = LEVEL_RESET;
      mean    = MEAN_RESET;
      bit_acc = '0;
      bit_cnt = '0;
      errors  = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [7:0] data);
      case (idx)
        REG_ENABLE:            en    = data[0];
        REG_AVG_SHIFT:         shift = data[SHIFT_W-1:0];
        REG_THRESHOLD_PERCENT: pct   = data[PCT_W-1:0];
        REG_INITIAL_LEVEL:     level = data;
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [7:0] pixel, logic fs);
      int unsigned tone, sum, pct_eff, thr;
      if (fs) begin
        mean    = MEAN_W'(32'(level) << shift);
        bit_acc = '0;
        bit_cnt = '0;
      end
      if (!en) return;
      tone = (pixel < KNEE) ? (32'(pixel) * 32'(pixel)) / 32'(KNEE) : 32'(WHITE);
      sum  = 32'(mean) - (32'(mean) >> shift) + tone;
      if (sum > 32'(MEAN_MAX)) sum = 32'(MEAN_MAX);
      mean = sum[MEAN_W-1:0];
      pct_eff = (pct > PCT_FULL) ? 32'(PCT_FULL) : 32'(pct);
      thr = (32'(mean) >> shift) * (32'(PCT_FULL) - pct_eff) / 32'(PCT_FULL);
      if (tone > thr) bit_acc[7 - bit_cnt] = 1'b1;
      if (bit_cnt == 3'd7) begin
        pending_bytes.push_back(bit_acc);
        bit_acc = '0;
        bit_cnt = '0;
      end else begin
        bit_cnt = bit_cnt + 3'd1;
      end
    endfunction

    function void check_byte(logic [7:0] got);
      logic [7:0] want;
      if (pending_bytes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("packed byte %02h arrived with none expected", got);
        return;
      end
      want = pending_bytes.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("packed byte mismatch: expected %02h, got %02h", want, got);
      end
    endfunction

    function int unsigned pending();
      return pending_bytes.size();
    endfunction

    function void flag_leftover();
      if (pending_bytes.size() != 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0d packed bytes never arrived", pending_bytes.size());
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  abb_pix_if  pix_ch();
  abb_byte_if byte_ch();
  abb_cfg_if  cfg_ch();

  adaptive_binarize_bitpack dut (
    .clk    (clk),
    .rst    (rst),
    .pixels (pix_ch),
    .bytes  (byte_ch),
    .cfg    (cfg_ch)
  );

  pack_scoreboard sb = new();

  // Pacing knobs, set per phase by the main sequence.
  bit          steady_tx;      // sender offers back to back
  bit          steady_rx;      // receiver never stalls
  int unsigned hold_requests;  // long receiver holds asked for so far
  int unsigned scene_level;    // current local brightness of the image
  int unsigned cycle_count;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Drive every block input to a known value from time zero.
  initial begin
    pix_ch.valid       <= 1'b0;
    pix_ch.pixel       <= '0;
    pix_ch.frame_start <= 1'b0;
    byte_ch.ready      <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= REG_ENABLE;
    cfg_ch.data        <= '0;
  end

  // Watchdog: end the run if the stream hangs.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Offer one pixel after a random gap; hold it until the block takes it.
  // valid stays high after the transfer so back-to-back pixels need no
  // second assignment in the same step.
  task automatic send_pixel(input logic [7:0] pixel, input logic fs);
    int unsigned gap;
    gap = steady_tx ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel       <= pixel;
    pix_ch.frame_start <= fs;
    do @(posedge clk); while (!pix_ch.ready);
    sb.note_pixel(pixel, fs);
  endtask

  task automatic program_reg(input cfg_index_t idx, input logic [7:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
  endtask

  // Write all four registers in one burst, then drop valid once.
  task automatic apply_settings(input logic en, input logic [2:0] shift,
                                input logic [6:0] pct, input logic [7:0] level);
    program_reg(REG_ENABLE, {7'd0, en});
    program_reg(REG_AVG_SHIFT, {5'd0, shift});
    program_reg(REG_THRESHOLD_PERCENT, {1'b0, pct});
    program_reg(REG_INITIAL_LEVEL, level);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stop offering, wait for every predicted byte, then let pixels that
  // finish no byte clear the pipeline before registers change.
  task automatic wait_idle();
    pix_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Image-like content: mostly a drifting local level with noise, some
  // uniform noise and some values right around the tone-curve knee.
  function automatic logic [7:0] draw_pixel();
    int v;
    case ($urandom_range(0, 7))
      0: return 8'($urandom_range(0, 255));
      1: return 8'($urandom_range(140, 160));
      default: begin
        if ($urandom_range(0, 15) == 0) scene_level = $urandom_range(0, 255);
        v = int'(scene_level) + int'($urandom_range(0, 40)) - 20;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
      end
    endcase
  endfunction

  // Output side: random stall before each byte, plus the long holds that
  // the main sequence requests to fill the block and stall its input.
  initial begin
    int unsigned stall;
    int unsigned holds_served;
    int unsigned held;
    holds_served = 0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_requests > holds_served) begin
        holds_served++;
        byte_ch.ready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
      end
      stall = steady_rx ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        byte_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      byte_ch.ready <= 1'b1;
      do @(posedge clk); while (!byte_ch.valid);
      sb.check_byte(byte_ch.packed_byte);
    end
  end

  initial begin
    int unsigned frame_left;
    int unsigned count;
    logic        fs;
    logic        en;
    logic [2:0]  shift;
    logic [6:0]  pct;
    logic [7:0]  level;

    steady_tx     = 1'b0;
    steady_rx     = 1'b0;
    hold_requests = 0;
    scene_level   = 128;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, field extremes and the knee, one full byte.
    send_pixel(8'd0,   1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd149, 1'b0);
    send_pixel(8'd150, 1'b0);
    send_pixel(8'd1,   1'b0);
    send_pixel(8'd148, 1'b0);
    send_pixel(8'd254, 1'b0);
    send_pixel(8'd127, 1'b0);
    // Partial byte, then a frame start that drops it and reloads the mean.
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd10,  1'b0);
    send_pixel(8'd90,  1'b0);
    send_pixel(8'd60,  1'b1);
    send_pixel(8'd151, 1'b0);
    send_pixel(8'd0,   1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd30,  1'b0);
    send_pixel(8'd75,  1'b0);
    send_pixel(8'd149, 1'b0);
    send_pixel(8'd100, 1'b0);
    send_pixel(8'd220, 1'b0);
    wait_idle();

    // Disabled: pixels vanish, but a frame start still reloads and clears.
    apply_settings(1'b0, 3'd5, 7'd15, 8'd30);
    send_pixel(8'd220, 1'b0);
    send_pixel(8'd5,   1'b1);
    send_pixel(8'd180, 1'b0);
    wait_idle();

    // Random phases. The first ones pin the extremes: a zero shift that
    // replaces the sum, a percent over one hundred, full and empty levels.
    for (int unsigned k = 0; k < PHASE_COUNT; k++) begin
      case (k)
        0: begin en = 1'b1; shift = 3'd0; pct = 7'd127; level = 8'd255; end
        1: begin en = 1'b1; shift = 3'd7; pct = 7'd0;   level = 8'd0;   end
        2: begin en = 1'b1; shift = 3'd1; pct = 7'd100; level = 8'd128; end
        3: begin en = 1'b1; shift = 3'd7; pct = 7'd101; level = 8'd255; end
        5: begin en = 1'b0; shift = 3'd2; pct = 7'd50;  level = 8'd127; end
        default: begin
          en    = 1'b1;
          shift = 3'($urandom_range(0, 7));
          pct   = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(101, 127))
                                              : 7'($urandom_range(0, 100));
          level = 8'($urandom_range(0, 255));
        end
      endcase
      apply_settings(en, shift, pct, level);

      steady_tx = (k % 4 == 3);
      steady_rx = (k % 4 == 2);
      // Hold the output for a long stretch while the sender keeps pushing.
      if (k == 3 || k == 11) hold_requests++;

      // Half the phases run on in the old frame, so the new level only takes hold
      // at the next frame start.
      frame_left = $urandom_range(0, 1) ? $urandom_range(8, 64) : 0;
      count = en ? PHASE_PIXELS : OFF_PIXELS;
      for (int unsigned i = 0; i < count; i++) begin
        if (frame_left == 0) begin
          fs = 1'b1;
          frame_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 23)
                                                   : 8 * $urandom_range(2, 20);
        end else begin
          // Stray frame start in mid frame: drop the partial byte.
          fs = ($urandom_range(0, 63) == 0);
        end
        send_pixel(draw_pixel(), fs);
        frame_left--;
      end
      wait_idle();
    end

    repeat (SETTLE) @(posedge clk);
    sb.flag_leftover();
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
